// ===== sv/lhc_pkg.sv =====
// Package with shared constants, types and command codes for the hunk cache.
package lhc_pkg;

  localparam int SLOTS       = 32;
  localparam int LOOKAHEAD   = 8;
  localparam int QUEUE_DEPTH = 16;
  // Queue storage has room for a full queue plus one lookahead batch.
  localparam int QSTORE      = 1 << $clog2(QUEUE_DEPTH + LOOKAHEAD);
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int QPTR_W      = $clog2(QSTORE);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + LOOKAHEAD + 1);
  localparam int LA_W        = $clog2(LOOKAHEAD + 1);
  localparam int KEEP_LIMIT  = (2 * LOOKAHEAD) < QUEUE_DEPTH ? (2 * LOOKAHEAD) : QUEUE_DEPTH;
  localparam logic [63:0] AGE_BIAS = 64'(SLOTS / 2);

  // Command codes.
  localparam logic [1:0] CMD_READ = 2'd0;
  localparam logic [1:0] CMD_TAKE = 2'd1;
  localparam logic [1:0] CMD_DONE = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_WAIT     = 3'd1;
  localparam logic [2:0] ST_MISS     = 3'd2;
  localparam logic [2:0] ST_PF_ALLOC = 3'd3;
  localparam logic [2:0] ST_PF_SKIP  = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;
  localparam logic [2:0] ST_NO_VICT  = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,      // slot scan for lookup and victim
    S_DECIDE,
    S_LA_SCAN,   // lookahead candidate check over slots and queue
    S_LA_NEXT,
    S_TRIM,      // drop oldest entries beyond the keep limit
    S_FINISH
  } lhc_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic scan_clear;   // reset the scan accumulators and index
    logic scan_step;    // look at one slot (and one queue entry)
    logic latch_cmd;    // capture input item
    logic apply_read;   // update slot after read decision
    logic apply_take;   // pop the head and claim a slot for it
    logic apply_done;   // mark slot ready
    logic la_load;      // load next lookahead candidate
    logic la_push;      // append candidate to queue
    logic trim_step;    // drop one head entry
    logic emit;         // drive the result strobe
  } lhc_ctrl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       scan_last;
    logic       found;
    logic       have_victim;
    logic       queue_empty;
    logic       la_ok;        // candidate below limit and not present
    logic       la_last;
    logic       over_keep;
  } lhc_stat_t;

endpackage

// ===== sv/lru_hunk_cache_with_prefetch_unit.sv =====
// Top level of the hunk cache tag and replacement controller.
//
//  channel | ports                                             | transfer
//  input   | start, busy, in_command, in_hunk_index, in_done_slot | start && !busy
//  result  | out_valid, out_status ... out_queue_count          | out_valid, one cycle
//  config  | cfg_we, cfg_wdata (total_hunks)                    | cfg_we
//
// Busy stays high through a scan of every slot on a read and on a take from a
// non-empty queue. A read that is served then runs the lookahead, one more
// scan for each of the eight lookahead hunks, and drops the queue entries
// beyond the keep limit (at most eight). A take from an empty queue and a done
// ack need no scan. The scan looks at one slot per cycle.
// The result shows in the first cycle with busy low, and the next transfer
// may be taken in that cycle. Reset is synchronous, active low, and clears
// all slots and the queue at once. The receiver cannot stall.
module lru_hunk_cache_with_prefetch_unit import lhc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_hunk_index,
  input  logic [4:0]  in_done_slot,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [4:0]  out_slot_index,
  output logic [31:0] out_decode_hunk,
  output logic        out_decode_start,
  output logic [4:0]  out_queue_count,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  lhc_ctrl_t ctrl;
  lhc_stat_t stat;
  logic      ctrl_busy;

  // Command 3 is dropped: never accepted into the sequencer.
  lhc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start && in_command != CMD_NONE),
    .busy  (ctrl_busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  assign busy = ctrl_busy;

  lhc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_command       (in_command),
    .in_hunk_index    (in_hunk_index),
    .in_done_slot     (in_done_slot),
    .ctrl             (ctrl),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_decode_hunk  (out_decode_hunk),
    .out_decode_start (out_decode_start),
    .out_queue_count  (out_queue_count)
  );

endmodule

// ===== sv/lhc_ctrl.sv =====
// Controller state machine sequencing slot scans, lookahead and queue upkeep.
module lhc_ctrl import lhc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  lhc_stat_t  stat,
  output lhc_ctrl_t  ctrl
);

  lhc_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.latch_cmd  = 1'b1;
          ctrl.scan_clear = 1'b1;
          state_nxt       = S_SCAN;
        end
      end
      S_SCAN: begin
        // A done and a take from an empty queue need no slot scan.
        if (stat.cmd == CMD_DONE) begin
          ctrl.apply_done = 1'b1;
          state_nxt       = S_FINISH;
        end else if (stat.cmd == CMD_TAKE && stat.queue_empty) begin
          state_nxt = S_FINISH;
        end else begin
          ctrl.scan_step = 1'b1;
          if (stat.scan_last) state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.cmd == CMD_READ) begin
          ctrl.apply_read = 1'b1;
          if (stat.found || stat.have_victim) begin
            ctrl.la_load = 1'b1;
            state_nxt    = S_LA_SCAN;
          end else begin
            state_nxt = S_FINISH;
          end
        end else begin
          ctrl.apply_take = 1'b1;
          state_nxt       = S_FINISH;
        end
      end
      S_LA_SCAN: begin
        ctrl.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = S_LA_NEXT;
      end
      S_LA_NEXT: begin
        if (stat.la_ok) ctrl.la_push = 1'b1;
        if (stat.la_last) begin
          state_nxt = S_TRIM;
        end else begin
          ctrl.la_load = 1'b1;
          state_nxt    = S_LA_SCAN;
        end
      end
      S_TRIM: begin
        if (stat.over_keep) ctrl.trim_step = 1'b1;
        else state_nxt = S_FINISH;
      end
      S_FINISH: begin
        ctrl.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== sv/lhc_datapath.sv =====
// Datapath: slot tables, age clock, prefetch queue and scan accumulators.
module lhc_datapath import lhc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic [1:0]        in_command,
  input  logic [31:0]       in_hunk_index,
  input  logic [4:0]        in_done_slot,
  input  lhc_ctrl_t         ctrl,
  output lhc_stat_t         stat,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [4:0]        out_slot_index,
  output logic [31:0]       out_decode_hunk,
  output logic              out_decode_start,
  output logic [4:0]        out_queue_count
);

  logic [31:0]      total_r;
  logic [31:0]      slot_tag_r   [SLOTS];
  logic [SLOTS-1:0] slot_valid_r;
  logic [SLOTS-1:0] slot_ready_r;
  logic [63:0]      slot_age_r   [SLOTS];
  logic [63:0]      age_clock_r;
  logic [31:0]      queue_r      [QSTORE];
  logic [QPTR_W-1:0] head_r;
  logic [QCNT_W-1:0] fill_r;

  logic [1:0]        cmd_r;
  logic [31:0]       hunk_r;
  logic [4:0]        done_r;
  logic [31:0]       key_r;       // tag being searched
  logic [SLOT_W:0]   idx_r;       // scan index, wide enough to hold SLOTS
  logic              found_r;
  logic              found_rdy_r;
  logic [SLOT_W-1:0] found_slot_r;
  logic              vic_r;
  logic [SLOT_W-1:0] vic_slot_r;
  logic [63:0]       vic_age_r;
  logic              inq_r;
  logic [LA_W-1:0]   k_r;

  logic [2:0]        res_status_r;
  logic [4:0]        res_slot_r;
  logic [31:0]       res_dh_r;
  logic              res_start_r;
  logic              valid_r;

  logic [2:0]        out_status_q;
  logic [4:0]        out_slot_q;
  logic [31:0]       out_dh_q;
  logic              out_start_q;
  logic [4:0]        out_count_q;

  logic [SLOT_W-1:0] sidx;
  logic [QPTR_W-1:0] qidx;
  logic              q_in_range;
  logic              vic_ok;
  logic [63:0]       clk_inc;
  logic [31:0]       head_val;
  logic [QPTR_W-1:0] tail;

  assign sidx       = idx_r[SLOT_W-1:0];
  assign qidx       = QPTR_W'(head_r + QPTR_W'(idx_r));
  assign q_in_range = (idx_r < (SLOT_W+1)'(fill_r)) && (int'(idx_r) < QUEUE_DEPTH);
  assign vic_ok     = (!slot_valid_r[sidx] || slot_ready_r[sidx]) &&
                      (!vic_r || slot_age_r[sidx] < vic_age_r);
  assign clk_inc    = age_clock_r + 64'd1;
  assign head_val   = queue_r[head_r];
  assign tail       = QPTR_W'(head_r + QPTR_W'(fill_r));

  // Status toward the controller.
  always_comb begin
    stat             = '0;
    stat.cmd         = cmd_r;
    stat.scan_last   = (int'(idx_r) == SLOTS - 1);
    stat.found       = found_r;
    stat.have_victim = vic_r;
    stat.queue_empty = (fill_r == '0);
    stat.la_ok       = (key_r < total_r) && !found_r && !inq_r;
    stat.la_last     = (int'(k_r) == LOOKAHEAD);
    stat.over_keep   = (int'(fill_r) > KEEP_LIMIT);
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) total_r <= '0;
    else if (cfg_we) total_r <= cfg_wdata;
  end

  // Queue storage; lookahead appends at the tail, take and trim advance the head.
  always_ff @(posedge clk) begin
    if (ctrl.la_push) queue_r[tail] <= key_r;
  end

  // Slot tag and age storage.
  always_ff @(posedge clk) begin
    if (ctrl.apply_read && !found_r && vic_r) slot_tag_r[vic_slot_r] <= hunk_r;
    if (ctrl.apply_take && !found_r && vic_r) slot_tag_r[vic_slot_r] <= head_val;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_age_r[i] <= '0;
    end else if (ctrl.apply_read && (found_r || vic_r)) begin
      slot_age_r[found_r ? found_slot_r : vic_slot_r] <= clk_inc;
    end else if (ctrl.apply_take && !found_r && vic_r) begin
      slot_age_r[vic_slot_r] <= (clk_inc > AGE_BIAS) ? clk_inc - AGE_BIAS : '0;
    end
  end

  // Control state: valid and ready bits, clock, queue pointers, scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      slot_ready_r <= '0;
      age_clock_r  <= '0;
      head_r       <= '0;
      fill_r       <= '0;
      idx_r        <= '0;
      valid_r      <= 1'b0;
    end else begin
      valid_r <= ctrl.emit;
      if (ctrl.latch_cmd) begin
        cmd_r  <= in_command;
        hunk_r <= in_hunk_index;
        done_r <= in_done_slot;
        key_r  <= (in_command == CMD_TAKE) ? queue_r[head_r] : in_hunk_index;
        k_r    <= '0;
        res_status_r <= (in_command == CMD_TAKE && fill_r == '0) ? ST_PF_SKIP : ST_DONE;
        res_slot_r   <= '0;
        res_dh_r     <= '0;
        res_start_r  <= 1'b0;
      end
      if (ctrl.scan_clear || ctrl.la_load) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        vic_r   <= 1'b0;
        inq_r   <= 1'b0;
      end
      if (ctrl.la_load) begin
        key_r <= hunk_r + 32'(k_r) + 32'd1;
        k_r   <= k_r + LA_W'(1);
      end
      if (ctrl.scan_step) begin
        idx_r <= idx_r + 1'b1;
        if (!found_r && slot_valid_r[sidx] && slot_tag_r[sidx] == key_r) begin
          found_r      <= 1'b1;
          found_rdy_r  <= slot_ready_r[sidx];
          found_slot_r <= sidx;
        end
        if (vic_ok) begin
          vic_r      <= 1'b1;
          vic_slot_r <= sidx;
          vic_age_r  <= slot_age_r[sidx];
        end
        if (q_in_range && queue_r[qidx] == key_r) inq_r <= 1'b1;
      end
      if (ctrl.la_push) fill_r <= fill_r + 1'b1;
      if (ctrl.trim_step) begin
        head_r <= head_r + 1'b1;
        fill_r <= fill_r - 1'b1;
      end
      if (ctrl.apply_done) begin
        if (int'(done_r) < SLOTS && slot_valid_r[SLOT_W'(done_r)])
          slot_ready_r[SLOT_W'(done_r)] <= 1'b1;
        res_status_r <= ST_DONE;
        res_slot_r   <= done_r;
      end
      if (ctrl.apply_read) begin
        if (found_r) begin
          res_status_r <= found_rdy_r ? ST_HIT : ST_WAIT;
          res_slot_r   <= 5'(found_slot_r);
          age_clock_r  <= clk_inc;
        end else if (vic_r) begin
          res_status_r <= ST_MISS;
          res_slot_r   <= 5'(vic_slot_r);
          res_dh_r     <= hunk_r;
          res_start_r  <= 1'b1;
          age_clock_r  <= clk_inc;
          slot_valid_r[vic_slot_r] <= 1'b1;
          slot_ready_r[vic_slot_r] <= 1'b0;
        end else begin
          res_status_r <= ST_NO_VICT;
        end
      end
      if (ctrl.apply_take) begin
        head_r <= head_r + 1'b1;
        fill_r <= fill_r - 1'b1;
        if (found_r) begin
          res_status_r <= ST_PF_SKIP;
        end else if (vic_r) begin
          res_status_r <= ST_PF_ALLOC;
          res_slot_r   <= 5'(vic_slot_r);
          res_dh_r     <= head_val;
          res_start_r  <= 1'b1;
          age_clock_r  <= clk_inc;
          slot_valid_r[vic_slot_r] <= 1'b1;
          slot_ready_r[vic_slot_r] <= 1'b0;
        end else begin
          res_status_r <= ST_NO_VICT;
        end
      end
    end
  end

  // Result register, loaded on emit and marked by out_valid for one cycle.
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_status_q      <= res_status_r;
      out_slot_q        <= res_slot_r;
      out_dh_q          <= res_dh_r;
      out_start_q       <= res_start_r;
      out_count_q       <= 5'(fill_r);
    end
  end

  assign out_valid        = valid_r;
  assign out_status       = out_status_q;
  assign out_slot_index   = out_slot_q;
  assign out_decode_hunk  = out_dh_q;
  assign out_decode_start = out_start_q;
  assign out_queue_count  = out_count_q;

endmodule

// ===== sv/lhc_checker.sv =====
// Port-level checker for the hunk cache, bound to the top level.
module lhc_checker import lhc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic        out_decode_start,
  input logic [4:0]  out_queue_count
);

  // A result never appears in consecutive cycles.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back results");

  // Decode starts only on allocation.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decode_start |-> (out_status == ST_MISS || out_status == ST_PF_ALLOC))
    else $error("decode start without allocation");

  // Queue count stays within the queue.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_queue_count) <= QUEUE_DEPTH) else $error("queue overflow");

  // Busy is low whenever a result is out.
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy with result out");

endmodule

bind lru_hunk_cache_with_prefetch_unit lhc_checker u_chk (
  .clk (clk), .rst_n (rst_n), .busy (busy),
  .out_valid (out_valid), .out_status (out_status),
  .out_decode_start (out_decode_start), .out_queue_count (out_queue_count)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the hunk cache tag and replacement controller.
`timescale 1ns / 1ps

module testbench import lhc_pkg::*; ();

  localparam int SETTLE_CYCLES = 600;
  localparam int OWED_DEPTH    = 4;
  localparam int PF_ROOM       = KEEP_LIMIT + LOOKAHEAD;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot_index;
    logic [31:0] decode_hunk;
    logic        decode_start;
    logic [4:0]  queue_count;
  } cache_result_t;

  // Scoreboard: shadow copy of the cache state and the results still owed.
  class cache_scoreboard;
    logic [31:0]   total_hunks;
    logic [31:0]   tag[SLOTS];
    bit            valid[SLOTS];
    bit            ready[SLOTS];
    logic [63:0]   age[SLOTS];
    logic [63:0]   age_clock;
    logic [31:0]   pf_q[PF_ROOM];
    int            pf_count;
    cache_result_t owed_q[OWED_DEPTH];
    int            owed_rd;
    int            owed_count;
    int            fails;

    function new();
      total_hunks = '0;
      age_clock = '0;
      pf_count = 0;
      owed_rd = 0;
      owed_count = 0;
      fails = 0;
      for (int i = 0; i < SLOTS; i++) begin
        tag[i] = '1;
        valid[i] = 0;
        ready[i] = 0;
        age[i] = '0;
      end
    endfunction

    function int find_hunk(logic [31:0] h);
      for (int i = 0; i < SLOTS; i++)
        if (valid[i] && tag[i] == h) return i;
      return -1;
    endfunction

    // Oldest empty or ready slot, lowest index on a tie.
    function int oldest_free();
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++)
        if ((!valid[i] || ready[i]) && (best < 0 || age[i] < age[best])) best = i;
      return best;
    endfunction

    function void claim(int s, logic [31:0] h, logic [63:0] a);
      tag[s] = h;
      valid[s] = 1;
      ready[s] = 0;
      age[s] = a;
    endfunction

    // Drop the n oldest queue entries.
    function void drop_oldest(int n);
      for (int j = 0; j < pf_count - n; j++) pf_q[j] = pf_q[j + n];
      pf_count -= n;
    endfunction

    // Remove and return the oldest queue entry.
    function logic [31:0] take_head();
      logic [31:0] h;
      h = pf_q[0];
      drop_oldest(1);
      return h;
    endfunction

    // Queue the next hunks after base, then keep only the newest entries.
    function void queue_lookahead(logic [31:0] base);
      logic [31:0] h;
      bit          present;
      int          old_count;
      old_count = pf_count;
      for (int k = 1; k <= LOOKAHEAD; k++) begin
        h = base + 32'(k);
        present = 0;
        for (int j = 0; j < old_count; j++) if (pf_q[j] == h) present = 1;
        if (h < total_hunks && find_hunk(h) < 0 && !present) begin
          pf_q[pf_count] = h;
          pf_count++;
        end
      end
      if (pf_count > KEEP_LIMIT) drop_oldest(pf_count - KEEP_LIMIT);
    endfunction

    // Called for each accepted command; works out the result it owes.
    function void note_command(logic [1:0] cmd, logic [31:0] hunk, logic [4:0] done_slot);
      cache_result_t r;
      int            s;
      logic [31:0]   h;
      r = '0;
      if (cmd == CMD_NONE) return;
      if (cmd == CMD_READ) begin
        s = find_hunk(hunk);
        if (s >= 0) begin
          r.status = ready[s] ? ST_HIT : ST_WAIT;
        end else begin
          s = oldest_free();
          if (s >= 0) begin
            claim(s, hunk, '0);
            r.status = ST_MISS;
            r.decode_start = 1;
            r.decode_hunk = hunk;
          end else begin
            r.status = ST_NO_VICT;
          end
        end
        if (s >= 0) begin
          age_clock++;
          age[s] = age_clock;
          r.slot_index = 5'(s);
          queue_lookahead(hunk);
        end
      end else if (cmd == CMD_TAKE) begin
        if (pf_count == 0) begin
          r.status = ST_PF_SKIP;
        end else begin
          h = take_head();
          if (find_hunk(h) >= 0) begin
            r.status = ST_PF_SKIP;
          end else begin
            s = oldest_free();
            if (s < 0) begin
              r.status = ST_NO_VICT;
            end else begin
              age_clock++;
              claim(s, h, age_clock > AGE_BIAS ? age_clock - AGE_BIAS : '0);
              r.status = ST_PF_ALLOC;
              r.slot_index = 5'(s);
              r.decode_start = 1;
              r.decode_hunk = h;
            end
          end
        end
      end else begin
        if (valid[done_slot]) ready[done_slot] = 1;
        r.status = ST_DONE;
        r.slot_index = done_slot;
      end
      r.queue_count = 5'(pf_count);
      owed_q[(owed_rd + owed_count) % OWED_DEPTH] = r;
      owed_count++;
    endfunction

    function void check_result(cache_result_t got);
      cache_result_t exp;
      if (owed_count == 0) begin
        $error("unexpected result: status %0d slot %0d", got.status, got.slot_index);
        fails++;
        return;
      end
      exp = owed_q[owed_rd];
      owed_rd = (owed_rd + 1) % OWED_DEPTH;
      owed_count--;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        fails++;
      end
      if (got.slot_index !== exp.slot_index) begin
        $error("slot_index: expected %0d, got %0d", exp.slot_index, got.slot_index);
        fails++;
      end
      if (got.decode_hunk !== exp.decode_hunk) begin
        $error("decode_hunk: expected %h, got %h", exp.decode_hunk, got.decode_hunk);
        fails++;
      end
      if (got.decode_start !== exp.decode_start) begin
        $error("decode_start: expected %0d, got %0d", exp.decode_start, got.decode_start);
        fails++;
      end
      if (got.queue_count !== exp.queue_count) begin
        $error("queue_count: expected %0d, got %0d", exp.queue_count, got.queue_count);
        fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [31:0] in_hunk_index;
  logic [4:0]  in_done_slot;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [4:0]  out_slot_index;
  logic [31:0] out_decode_hunk;
  logic        out_decode_start;
  logic [4:0]  out_queue_count;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  cache_scoreboard sb;

  lru_hunk_cache_with_prefetch_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_hunk_index(in_hunk_index), .in_done_slot(in_done_slot),
    .out_valid(out_valid), .out_status(out_status), .out_slot_index(out_slot_index),
    .out_decode_hunk(out_decode_hunk), .out_decode_start(out_decode_start),
    .out_queue_count(out_queue_count), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Every result strobe is checked against the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result({out_status, out_slot_index, out_decode_hunk,
                       out_decode_start, out_queue_count});
  end

  // Present one command and hold it until the transfer happens.
  task automatic send_command(logic [1:0] cmd, logic [31:0] hunk, logic [4:0] done_slot);
    start <= 1'b1;
    in_command <= cmd;
    in_hunk_index <= hunk;
    in_done_slot <= done_slot;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_command(cmd, hunk, done_slot);
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drain all owed results, then let any ignored command finish.
  task automatic drain();
    start <= 1'b0;
    while (sb.owed_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(logic [31:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.total_hunks = value;
  endtask

  // One random command; done_pct sets how often decodes finish.
  task automatic random_command(int done_pct, logic [31:0] base);
    int          r;
    int          m;
    logic [31:0] hunk;
    r = $urandom_range(0, 99);
    m = $urandom_range(0, 9);
    if (m == 0) hunk = $urandom;
    else if (m == 1) hunk = 32'hFFFF_FFFF - 32'($urandom_range(0, 12));
    else hunk = base + 32'($urandom_range(0, 47));
    if (r < 4)
      send_command(CMD_NONE, $urandom, 5'($urandom));
    else if (r < 4 + done_pct)
      send_command(CMD_DONE, $urandom, 5'($urandom));
    else if (r < 4 + done_pct + (96 - done_pct) / 3)
      send_command(CMD_TAKE, $urandom, 5'($urandom));
    else
      send_command(CMD_READ, hunk, 5'($urandom));
  endtask

  initial begin
    logic [31:0] totals[5];
    logic [31:0] bases[5];
    int          done_pcts[5];
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_READ;
    in_hunk_index = '0;
    in_done_slot = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty queue, miss, wait, hit, takes, bad done, all-ones hunk.
    send_command(CMD_TAKE, '0, '0);
    send_command(CMD_READ, '0, '0);
    write_total(32'd20);
    send_command(CMD_READ, 32'd0, '0);
    send_command(CMD_READ, 32'd0, '0);
    send_command(CMD_DONE, '0, 5'd0);
    send_command(CMD_READ, 32'd0, '0);
    send_command(CMD_TAKE, '0, '0);
    send_command(CMD_TAKE, '0, '0);
    send_command(CMD_READ, 32'd2, '0);
    send_command(CMD_TAKE, '0, '0);
    send_command(CMD_DONE, '0, 5'd31);
    send_command(CMD_DONE, '0, 5'd1);
    send_command(CMD_NONE, 32'hFFFF_FFFF, 5'd31);
    write_total(32'hFFFF_FFFF);
    send_command(CMD_READ, 32'hFFFF_FFFF, '0);
    send_command(CMD_READ, 32'hFFFF_FFFF, '0);
    send_command(CMD_READ, 32'hFFFF_FFFC, '0);
    send_command(CMD_TAKE, '0, '0);
    send_command(CMD_TAKE, '0, '0);
    send_command(CMD_READ, 32'd15, '0);

    // Random phases; low done rates fill every slot with pending decodes.
    totals = '{32'd64, 32'hFFFF_FFFF, 32'd0, 32'd1000, 32'hFFFF_FFF0};
    bases = '{32'd0, 32'h8000_0000, 32'd0, 32'd960, 32'hFFFF_FFC8};
    done_pcts = '{25, 5, 30, 15, 20};
    for (int p = 0; p < 5; p++) begin
      write_total(totals[p]);
      for (int i = 0; i < 80; i++) begin
        random_command(done_pcts[p], bases[p]);
        if (i == 40) drain();
        else if (p < 4 && $urandom_range(0, 5) == 0) pause($urandom_range(1, 16));
      end
    end

    start <= 1'b0;
    while (sb.owed_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
sv/lhc_pkg.sv
sv/lhc_ctrl.sv
sv/lhc_datapath.sv
sv/lru_hunk_cache_with_prefetch_unit.sv
sv/lhc_checker.sv
verif/testbench.sv
